### rtl/core/cigar_five_prime_position_top_assert.svh
// Assertion macros for the CIGAR 5' position block.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CIGAR_FIVE_PRIME_POSITION_TOP_ASSERT_SVH
`define CIGAR_FIVE_PRIME_POSITION_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every rising edge outside reset.
`define CFPP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cfpp assertion failed");
// Condition in one cycle implies a consequence in the next.
`define CFPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `CFPP_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))
`else
`define CFPP_ASSERT(lbl, clk, rst_n, prop)
`define CFPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/cfpp_pkg.sv
// Shared types, constants and helpers for the CIGAR 5' position block.
// No dependencies.
package cfpp_pkg;

    localparam int OP_LEN_BITS = 28;
    localparam int SUM_BITS    = 32;
    localparam int LOC_BITS    = 31;
    localparam int POS_BITS    = 35; // signed working width of the final sum

    typedef logic [OP_LEN_BITS-1:0]   t_op_len;
    typedef logic [OP_LEN_BITS+3:0]   t_op_prod;
    typedef logic [SUM_BITS-1:0]      t_sum;
    typedef logic [LOC_BITS-1:0]      t_loc;
    typedef logic [POS_BITS-1:0]      t_pos;
    typedef logic [7:0]               t_char;
    typedef logic [2:0]               t_status;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_UNKNOWN  = 3'd1;
    localparam t_status ST_NEGATIVE = 3'd2;
    localparam t_status ST_ABOVE    = 3'd3;
    localparam t_status ST_TRUNC    = 3'd4;

    localparam t_char CH_0  = 8'h30;
    localparam t_char CH_9  = 8'h39;
    localparam t_char CH_M  = 8'h4D;
    localparam t_char CH_EQ = 8'h3D;
    localparam t_char CH_X  = 8'h58;
    localparam t_char CH_S  = 8'h53;
    localparam t_char CH_H  = 8'h48;
    localparam t_char CH_D  = 8'h44;
    localparam t_char CH_N  = 8'h4E;
    localparam t_char CH_I  = 8'h49;

    // Read totals as they stand after the last character of a read.
    typedef struct packed {
        t_loc    loc;
        logic    fwd;
        t_sum    start_clip;
        t_sum    ref_length;
        t_sum    end_clip;
        t_status err;
        logic    digits_pending;
    } t_snap;

    function automatic t_sum sat_add(input t_sum a, input t_sum b);
        logic [SUM_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
    endfunction

endpackage

### rtl/core/cfpp_if.sv
// Word channel interfaces for the CIGAR 5' position block.
// Depends on cfpp_pkg.
interface cfpp_in_if;
    logic              valid;
    logic              ready;
    cfpp_pkg::t_char   cigar_char;
    logic              last_char;
    cfpp_pkg::t_loc    read_location;
    logic              forward_strand;

    modport source (output valid, cigar_char, last_char, read_location, forward_strand,
                    input ready);
    modport sink   (input valid, cigar_char, last_char, read_location, forward_strand,
                    output ready);
endinterface

interface cfpp_out_if;
    logic              valid;
    logic              ready;
    cfpp_pkg::t_loc    position;
    cfpp_pkg::t_status status;

    modport source (output valid, position, status, input ready);
    modport sink   (input valid, position, status, output ready);
endinterface

### rtl/core/cfpp_acc.sv
// Per-character CIGAR accumulator: op length, clips, reference length, error.
// Depends on cfpp_pkg.
module cfpp_acc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  cfpp_pkg::t_char   i_char,
    input  logic              i_last,
    input  cfpp_pkg::t_loc    i_loc,
    input  logic              i_fwd,
    output cfpp_pkg::t_snap   o_snap
);

    cfpp_pkg::t_op_len r_op, n_op;
    cfpp_pkg::t_sum    r_ref, n_ref;
    cfpp_pkg::t_sum    r_start, n_start;
    cfpp_pkg::t_sum    r_end, n_end;
    logic              r_seen, n_seen;
    logic              r_dp, n_dp;
    cfpp_pkg::t_status r_err, n_err;

    logic               is_digit;
    logic [3:0]         digit;
    cfpp_pkg::t_op_prod prod;
    cfpp_pkg::t_op_len  op_sat;
    cfpp_pkg::t_sum     len;

    assign is_digit = (i_char >= cfpp_pkg::CH_0) && (i_char <= cfpp_pkg::CH_9);
    assign digit    = 4'(i_char - cfpp_pkg::CH_0);
    // op * 10 + digit as shift-add
    assign prod     = ({4'b0, r_op} << 3) + ({4'b0, r_op} << 1)
                    + cfpp_pkg::t_op_prod'(digit);
    assign op_sat   = (prod[cfpp_pkg::OP_LEN_BITS+3:cfpp_pkg::OP_LEN_BITS] != 4'd0)
                    ? '1 : prod[cfpp_pkg::OP_LEN_BITS-1:0];
    assign len      = cfpp_pkg::t_sum'(r_op);

    always_comb begin
        n_op    = r_op;
        n_ref   = r_ref;
        n_start = r_start;
        n_end   = r_end;
        n_seen  = r_seen;
        n_dp    = r_dp;
        n_err   = r_err;
        if (is_digit) begin
            n_op = op_sat;
            n_dp = 1'b1;
        end else begin
            n_op = '0;
            n_dp = 1'b0;
            if (r_err == cfpp_pkg::ST_OK) begin
                unique case (i_char)
                    cfpp_pkg::CH_M, cfpp_pkg::CH_EQ, cfpp_pkg::CH_X: begin
                        n_ref  = cfpp_pkg::sat_add(r_ref, len);
                        n_seen = 1'b1;
                    end
                    cfpp_pkg::CH_S, cfpp_pkg::CH_H: begin
                        if (!r_seen) n_start = cfpp_pkg::sat_add(r_start, len);
                        else         n_end   = cfpp_pkg::sat_add(r_end, len);
                    end
                    cfpp_pkg::CH_D, cfpp_pkg::CH_N: begin
                        n_ref = cfpp_pkg::sat_add(r_ref, len);
                    end
                    cfpp_pkg::CH_I: begin
                        n_ref = r_ref; // insertion: reference does not move
                    end
                    default: begin
                        n_err = cfpp_pkg::ST_UNKNOWN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_op    <= '0;
            r_ref   <= '0;
            r_start <= '0;
            r_end   <= '0;
            r_seen  <= 1'b0;
            r_dp    <= 1'b0;
            r_err   <= cfpp_pkg::ST_OK;
        end else if (i_accept) begin
            r_op    <= n_op;
            r_ref   <= n_ref;
            r_start <= n_start;
            r_end   <= n_end;
            r_seen  <= n_seen;
            r_dp    <= n_dp;
            r_err   <= n_err;
        end
    end

    assign o_snap = '{loc: i_loc, fwd: i_fwd, start_clip: n_start, ref_length: n_ref,
                      end_clip: n_end, err: n_err, digits_pending: n_dp};

endmodule

### rtl/core/cigar_five_prime_position_top.sv
// Unclipped 5' position from a CIGAR string streamed one character per word.
// The block takes one character every cycle while input ready is high. Each accepted
// word updates the running op length, clips and reference length; the word flagged
// last also loads a snapshot register, and the position and status are formed from it
// into the output register, so a result passes the snapshot register and then the output
// register. Only last characters produce a result word. Input ready drops only while
// both the snapshot and the output register hold results and the output is stalled.
// Status: ok, unknown op, negative, above int32, truncated (digits with no op);
// position reads zero whenever status is not ok. Running state clears after each read.
// Depends on cfpp_pkg, cfpp_if.sv, cfpp_acc.sv and the assertion macro header.
`include "cigar_five_prime_position_top_assert.svh"

module cigar_five_prime_position_top (
    input  logic i_clk,
    input  logic i_rst_n,
    cfpp_in_if.sink    i_in,
    cfpp_out_if.source o_out
);

    logic            in_accept;
    logic            snap_advance;
    cfpp_pkg::t_snap acc_snap;

    // snapshot stage: totals of the read whose last char was just accepted
    logic            r_snap_v;
    cfpp_pkg::t_snap r_snap;

    // output register
    logic              r_out_v;
    cfpp_pkg::t_loc    r_pos;
    cfpp_pkg::t_status r_status;

    cfpp_pkg::t_pos    pos;
    logic              neg;
    logic              above;
    cfpp_pkg::t_status n_status;
    cfpp_pkg::t_loc    n_pos;

    assign snap_advance = r_snap_v && (!r_out_v || o_out.ready);
    assign i_in.ready   = !r_snap_v || snap_advance;
    assign in_accept    = i_in.valid && i_in.ready;

    cfpp_acc u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_char   (i_in.cigar_char),
        .i_last   (i_in.last_char),
        .i_loc    (i_in.read_location),
        .i_fwd    (i_in.forward_strand),
        .o_snap   (acc_snap)
    );

    // final sum in 35-bit two's complement: range is -(2^32-1)..2^33+2^31-4
    always_comb begin
        if (r_snap.fwd) begin
            pos = cfpp_pkg::t_pos'(r_snap.loc) - cfpp_pkg::t_pos'(r_snap.start_clip);
        end else begin
            pos = cfpp_pkg::t_pos'(r_snap.loc) + cfpp_pkg::t_pos'(r_snap.ref_length)
                + cfpp_pkg::t_pos'(r_snap.end_clip) - cfpp_pkg::t_pos'(1);
        end
    end

    assign neg   = pos[cfpp_pkg::POS_BITS-1];
    assign above = !neg && (pos[cfpp_pkg::POS_BITS-2:cfpp_pkg::LOC_BITS] != '0);

    always_comb begin
        priority if (r_snap.err != cfpp_pkg::ST_OK) n_status = r_snap.err;
        else if (r_snap.digits_pending)            n_status = cfpp_pkg::ST_TRUNC;
        else if (neg)                              n_status = cfpp_pkg::ST_NEGATIVE;
        else if (above)                            n_status = cfpp_pkg::ST_ABOVE;
        else                                       n_status = cfpp_pkg::ST_OK;
    end

    assign n_pos = (n_status == cfpp_pkg::ST_OK) ? pos[cfpp_pkg::LOC_BITS-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_v <= 1'b0;
        end else if (in_accept && i_in.last_char) begin
            r_snap_v <= 1'b1;
        end else if (snap_advance) begin
            r_snap_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in.last_char) begin
            r_snap <= acc_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (snap_advance) begin
            r_out_v <= 1'b1;
        end else if (o_out.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_advance) begin
            r_pos    <= n_pos;
            r_status <= n_status;
        end
    end

    assign o_out.valid    = r_out_v;
    assign o_out.position = r_pos;
    assign o_out.status   = r_status;

    // a last character always lands in the snapshot stage
    `CFPP_ASSERT_NEXT(a_last_loads_snap, i_clk, i_rst_n, in_accept && i_in.last_char, r_snap_v)
    // a snapshot that moves on always becomes a result word
    `CFPP_ASSERT_NEXT(a_snap_to_out, i_clk, i_rst_n, snap_advance, r_out_v)
    // failing status never carries a position
    `CFPP_ASSERT(a_err_pos_zero, i_clk, i_rst_n,
        !r_out_v || r_status == cfpp_pkg::ST_OK || r_pos == '0)
    // never stall input while the snapshot stage is free
    `CFPP_ASSERT(a_ready_when_free, i_clk, i_rst_n, r_snap_v || i_in.ready)

endmodule

### tb/sv/cfpp_position_monitor.sv
// Scoreboard for the CIGAR 5' position block: watches both word channels,
// predicts each read's position and status and compares them in order.
// Depends on cfpp_pkg and the channel interfaces in cfpp_if.sv.
module cfpp_position_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    cfpp_in_if   in_ch,
    cfpp_out_if  out_ch,
    output int   o_mismatches,
    output int   o_pending
);

    localparam longint OP_LEN_CAP = (longint'(1) << cfpp_pkg::OP_LEN_BITS) - 1;
    localparam longint INT32_TOP  = 64'sd2147483647;

    typedef struct packed {
        cfpp_pkg::t_loc    position;
        cfpp_pkg::t_status status;
    } t_five_prime;

    t_five_prime five_prime_q[$];
    t_five_prime want;

    // running totals of the read in flight
    cfpp_pkg::t_op_len run_len;
    cfpp_pkg::t_sum    ref_span;
    cfpp_pkg::t_sum    lead_clip;
    cfpp_pkg::t_sum    trail_clip;
    logic              past_lead;
    logic              len_open;
    cfpp_pkg::t_status latched_err;

    function automatic cfpp_pkg::t_sum add_clamped(input cfpp_pkg::t_sum acc,
                                                   input cfpp_pkg::t_op_len len);
        logic [cfpp_pkg::SUM_BITS:0] wide;
        wide = {1'b0, acc} + {{(cfpp_pkg::SUM_BITS + 1 - cfpp_pkg::OP_LEN_BITS){1'b0}}, len};
        return wide[cfpp_pkg::SUM_BITS] ? '1 : wide[cfpp_pkg::SUM_BITS-1:0];
    endfunction

    task automatic clear_read();
        run_len     = '0;
        ref_span    = '0;
        lead_clip   = '0;
        trail_clip  = '0;
        past_lead   = 1'b0;
        len_open    = 1'b0;
        latched_err = cfpp_pkg::ST_OK;
    endtask

    task automatic absorb_char(input cfpp_pkg::t_char c);
        longint            grown;
        cfpp_pkg::t_op_len len;
        if (c >= cfpp_pkg::CH_0 && c <= cfpp_pkg::CH_9) begin
            grown    = longint'(run_len) * 10 + longint'(c - cfpp_pkg::CH_0);
            run_len  = (grown > OP_LEN_CAP) ? '1 : cfpp_pkg::t_op_len'(grown);
            len_open = 1'b1;
        end else begin
            len      = run_len;
            run_len  = '0;
            len_open = 1'b0;
            // an unknown op freezes the totals until the read ends
            if (latched_err == cfpp_pkg::ST_OK) begin
                case (c)
                    cfpp_pkg::CH_M, cfpp_pkg::CH_EQ, cfpp_pkg::CH_X: begin
                        ref_span  = add_clamped(ref_span, len);
                        past_lead = 1'b1;
                    end
                    cfpp_pkg::CH_S, cfpp_pkg::CH_H: begin
                        if (!past_lead) begin
                            lead_clip = add_clamped(lead_clip, len);
                        end else begin
                            trail_clip = add_clamped(trail_clip, len);
                        end
                    end
                    cfpp_pkg::CH_D, cfpp_pkg::CH_N: begin
                        ref_span = add_clamped(ref_span, len);
                    end
                    cfpp_pkg::CH_I: begin
                    end
                    default: begin
                        latched_err = cfpp_pkg::ST_UNKNOWN;
                    end
                endcase
            end
        end
    endtask

    task automatic close_read(input cfpp_pkg::t_loc loc, input logic fwd);
        longint      where;
        t_five_prime res;
        if (fwd) begin
            where = longint'(loc) - longint'(lead_clip);
        end else begin
            where = longint'(loc) + longint'(ref_span) + longint'(trail_clip) - 1;
        end
        if (latched_err != cfpp_pkg::ST_OK) begin
            res.status = latched_err;
        end else if (len_open) begin
            res.status = cfpp_pkg::ST_TRUNC;
        end else if (where < 0) begin
            res.status = cfpp_pkg::ST_NEGATIVE;
        end else if (where > INT32_TOP) begin
            res.status = cfpp_pkg::ST_ABOVE;
        end else begin
            res.status = cfpp_pkg::ST_OK;
        end
        res.position = (res.status == cfpp_pkg::ST_OK) ? cfpp_pkg::t_loc'(where) : '0;
        five_prime_q.push_back(res);
        clear_read();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_read();
            five_prime_q.delete();
            o_mismatches = 0;
            o_pending   <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                absorb_char(in_ch.cigar_char);
                if (in_ch.last_char) begin
                    close_read(in_ch.read_location, in_ch.forward_strand);
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                if (five_prime_q.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected word: expected none, actual position %0d status %0d",
                             $time, out_ch.position, out_ch.status);
                end else begin
                    want = five_prime_q.pop_front();
                    if (out_ch.position !== want.position) begin
                        o_mismatches++;
                        $display("%0t: position: expected %0d, actual %0d",
                                 $time, want.position, out_ch.position);
                    end
                    if (out_ch.status !== want.status) begin
                        o_mismatches++;
                        $display("%0t: status: expected %0d, actual %0d",
                                 $time, want.status, out_ch.status);
                    end
                end
            end
            o_pending <= five_prime_q.size();
        end
    end

endmodule

### tb/sv/tb.sv
// Top of the CIGAR 5' position testbench: clock, reset, character stimulus
// and output stalls; the verdict comes from cfpp_position_monitor.
// Depends on cfpp_pkg, cfpp_if.sv, the block and cfpp_position_monitor.sv.
module tb;

    localparam int WORD_TARGET  = 1000;   // characters to send before the run ends
    localparam int PAUSE_AT     = 500;    // drain point for the sender
    localparam int QUIET_FROM   = 850;    // no idling from here on
    localparam int DRAIN_CYCLES = 8;      // extra wait after the drain
    localparam int CYCLE_LIMIT  = 100000;

    localparam cfpp_pkg::t_char CH_NUL  = 8'h00;
    localparam cfpp_pkg::t_char CH_TOP  = 8'hFF;
    localparam cfpp_pkg::t_loc  LOC_MAX = '1;

    logic        i_clk;
    logic        i_rst_n;
    logic        quiet_tail;
    int          mismatches;
    int          pending;
    int unsigned words_sent;
    int unsigned cycle_count;

    cfpp_in_if  in_ch ();
    cfpp_out_if out_ch ();

    cigar_five_prime_position_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    cfpp_position_monitor u_mon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or never drains.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Result side: ready drops at random in bursts, never in the quiet tail.
    initial begin
        int stall_left;
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // One character word. An idle burst, if any, comes before the word is
    // offered; valid then stays high until the handshake completes.
    task automatic send_word(input cfpp_pkg::t_char c, input logic last,
                             input cfpp_pkg::t_loc loc, input logic fwd);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.cigar_char     <= c;
        in_ch.last_char      <= last;
        in_ch.read_location  <= loc;
        in_ch.forward_strand <= fwd;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    // A whole CIGAR given as text; the last character carries the end flag.
    task automatic send_read(input string cigar, input cfpp_pkg::t_loc loc, input logic fwd);
        int i;
        for (i = 0; i < cigar.len(); i++) begin
            send_word(cfpp_pkg::t_char'(cigar[i]), i == cigar.len() - 1, loc, fwd);
        end
    endtask

    // Random read. Mostly well formed with random lengths and ops; some
    // reads end in bare digits, some carry a stray byte in place of an op,
    // and a few are pure byte noise.
    task automatic send_random_read();
        int              kind;
        int              n_ops;
        int              n_dig;
        int              i;
        int              j;
        cfpp_pkg::t_char op;
        cfpp_pkg::t_loc  loc;
        logic            fwd;
        logic            tail_digits;
        // small locations meet clips (negative), high ones meet spans (above int32)
        case ($urandom_range(0, 3))
            0:       loc = cfpp_pkg::t_loc'($urandom_range(0, 64));
            1:       loc = cfpp_pkg::t_loc'($urandom_range(32'h7FFF_FF00, 32'h7FFF_FFFF));
            default: loc = cfpp_pkg::t_loc'($urandom());
        endcase
        fwd  = 1'($urandom_range(0, 1));
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n_ops = $urandom_range(1, 8);
            for (i = 0; i < n_ops; i++) begin
                send_word(cfpp_pkg::t_char'($urandom_range(0, 255)), i == n_ops - 1,
                          cfpp_pkg::t_loc'($urandom()), 1'($urandom_range(0, 1)));
            end
        end else begin
            tail_digits = (kind == 1);
            n_ops = $urandom_range(1, 6);
            for (i = 0; i < n_ops; i++) begin
                // long digit runs push the op length into saturation
                n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 11)
                                                    : $urandom_range(0, 3);
                for (j = 0; j < n_dig; j++) begin
                    send_word(cfpp_pkg::CH_0 + cfpp_pkg::t_char'($urandom_range(0, 9)),
                              1'b0, loc, fwd);
                end
                case ($urandom_range(0, 7))
                    0:       op = cfpp_pkg::CH_M;
                    1:       op = cfpp_pkg::CH_EQ;
                    2:       op = cfpp_pkg::CH_X;
                    3:       op = cfpp_pkg::CH_S;
                    4:       op = cfpp_pkg::CH_H;
                    5:       op = cfpp_pkg::CH_D;
                    6:       op = cfpp_pkg::CH_N;
                    default: op = cfpp_pkg::CH_I;
                endcase
                if (kind == 2 && $urandom_range(0, n_ops - 1) == 0) begin
                    op = cfpp_pkg::t_char'($urandom_range(0, 255));
                end
                send_word(op, !tail_digits && i == n_ops - 1, loc, fwd);
            end
            if (tail_digits) begin
                n_dig = $urandom_range(1, 3);
                for (j = 0; j < n_dig; j++) begin
                    send_word(cfpp_pkg::CH_0 + cfpp_pkg::t_char'($urandom_range(0, 9)),
                              j == n_dig - 1, loc, fwd);
                end
            end
        end
    endtask

    initial begin
        int i;
        int j;
        bit paused_once;
        in_ch.valid          = 1'b0;
        in_ch.cigar_char     = '0;
        in_ch.last_char      = 1'b0;
        in_ch.read_location  = '0;
        in_ch.forward_strand = 1'b0;
        i_rst_n              = 1'b0;
        quiet_tail           = 1'b0;
        words_sent           = 0;
        paused_once          = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed reads
        send_read("M", '0, 1'b1);                 // op with no digits, location zero
        send_read("=", '0, 1'b0);                 // reverse, zero lengths: sum is -1
        send_read("5H1X2N3D4I1S", cfpp_pkg::t_loc'(100), 1'b0); // H, X, N, D, I and S ops, both clips
        send_word(CH_NUL, 1'b0, cfpp_pkg::t_loc'(5), 1'b1);      // NUL latches unknown op,
        send_word(cfpp_pkg::CH_M, 1'b1, cfpp_pkg::t_loc'(5), 1'b1); // later ops do nothing
        send_read("7", cfpp_pkg::t_loc'(42), 1'b1);              // bare digit at the end
        send_read("X", LOC_MAX, 1'b1);            // top location, forward
        send_word(CH_TOP, 1'b1, LOC_MAX, 1'b0);   // unknown op on the last word
        send_read("3S", cfpp_pkg::t_loc'(2), 1'b1);              // clip past the location
        send_read("3M", LOC_MAX, 1'b0);           // reverse sum above int32

        // Random reads
        while (words_sent < WORD_TARGET) begin
            if (!paused_once && words_sent >= PAUSE_AT) begin
                paused_once = 1'b1;
                // hold off until every result so far is back
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
                // 17 saturated lengths overflow the 32-bit reference span
                for (i = 0; i < 17; i++) begin
                    for (j = 0; j < 9; j++) begin
                        send_word(cfpp_pkg::CH_9, 1'b0, cfpp_pkg::t_loc'(1000), 1'b0);
                    end
                    send_word(cfpp_pkg::CH_M, i == 16, cfpp_pkg::t_loc'(1000), 1'b0);
                end
            end
            quiet_tail = (words_sent >= QUIET_FROM);
            send_random_read();
        end

        // Drain: the extra edge lets the last push reach the pending count.
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
